/* hdl/tbm_pkg.sv */
// Shared types and constants for the text bounding box measurement block.
package tbm_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_START  = 2'd1,
        ACT_CHAR   = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_START,
        KIND_NEWLINE,
        KIND_GLYPH,
        KIND_FINISH
    } kind_t;

    localparam logic [1:0] REG_FIRST_CHAR   = 2'd0;
    localparam logic [1:0] REG_LAST_CHAR    = 2'd1;
    localparam logic [1:0] REG_LINE_ADVANCE = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_RETURN  = 8'd13;

    localparam logic [7:0] FIRST_CHAR_RESET   = 8'd32;
    localparam logic [7:0] LAST_CHAR_RESET    = 8'd126;
    localparam logic [7:0] LINE_ADVANCE_RESET = 8'd0;

    localparam logic signed [31:0] BOX_EMPTY_MIN = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] BOX_EMPTY_MAX = -32'sd1;

    typedef struct packed {
        logic [7:0]        width;
        logic [7:0]        height;
        logic [7:0]        advance;
        logic signed [7:0] x_shift;
        logic signed [7:0] y_shift;
    } glyph_t;

endpackage

/* hdl/text_bounds_measure.sv */
// Text bounding box measurement: glyph metric table, cursor tracking and box report.
//
// Usage: a single input channel (in_valid / in_stall) carries one action per transfer.
// A load action writes one glyph metric entry, a start action places the cursor and
// clears the box, a character action may move the cursor and widen the box, and a
// finish action produces one result transfer on the output channel (out_valid /
// out_stall) holding box_x, box_y, box_width and box_height. Only finish produces
// a result. The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
// sets first_char, last_char and line_advance; it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
//
// Throughput is one action per cycle while in_stall is low. The glyph table read
// is registered, so an item waits in the input stage before it is applied to the
// cursor and box registers; a finish result passes through the input stage and
// the output register before it is offered on the output. Load, start and
// character actions keep flowing while a finished result waits for the receiver;
// a second finish waits in the input stage until the output register is taken, and
// in_stall rises behind it. After reset the cursor and origin are zero, the box is
// empty, the configuration holds its reset values and the glyph table is undefined.
module text_bounds_measure
    import tbm_pkg::*;
#(
    parameter int GLYPH_SLOTS = 128
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [6:0]         glyph_index,
    input  logic [7:0]         glyph_width,
    input  logic [7:0]         glyph_height,
    input  logic [7:0]         glyph_advance,
    input  logic signed [7:0]  glyph_x_offset,
    input  logic signed [7:0]  glyph_y_offset,
    input  logic [7:0]         char_code,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] box_x,
    output logic signed [31:0] box_y,
    output logic [31:0]        box_width,
    output logic [31:0]        box_height,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    // Table address width; a single-entry table still gets one address bit.
    localparam int IDX_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam logic [8:0] SLOTS = 9'(GLYPH_SLOTS);

    // Configuration registers.
    logic [7:0] first_char_reg;
    logic [7:0] last_char_reg;
    logic [7:0] line_advance_reg;

    // Input stage.
    logic              s1_valid_reg;
    kind_t             s1_kind_reg;
    logic signed [31:0] s1_start_x_reg;
    logic signed [31:0] s1_start_y_reg;
    glyph_t            glyph_rd_reg;

    // Measurement state.
    logic signed [31:0] cursor_x_reg, cursor_x_next;
    logic signed [31:0] cursor_y_reg, cursor_y_next;
    logic signed [31:0] origin_x_reg, origin_x_next;
    logic signed [31:0] origin_y_reg, origin_y_next;
    logic signed [31:0] min_x_reg, min_x_next;
    logic signed [31:0] min_y_reg, min_y_next;
    logic signed [31:0] max_x_reg, max_x_next;
    logic signed [31:0] max_y_reg, max_y_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] box_x_reg, box_x_next;
    logic signed [31:0] box_y_reg, box_y_next;
    logic [31:0]        box_width_reg, box_width_next;
    logic [31:0]        box_height_reg, box_height_next;

    glyph_t glyph_mem [GLYPH_SLOTS];

    // Handshake: the output slot is free when empty or being taken this cycle.
    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && ((s1_kind_reg != KIND_FINISH) || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Character classification at the input.
    logic [7:0] char_idx;
    logic       char_in_range;
    logic       char_idx_ok;
    logic [7:0] load_idx;
    logic       load_ok;
    kind_t      in_kind;

    assign char_idx      = char_code - first_char_reg;
    assign char_in_range = (char_code >= first_char_reg) && (char_code <= last_char_reg);
    assign char_idx_ok   = ({1'b0, char_idx} < SLOTS);
    assign load_idx      = {1'b0, glyph_index};
    assign load_ok       = ({1'b0, load_idx} < SLOTS);

    always_comb
    begin
        in_kind = KIND_NONE;
        unique case (action_t'(action))
            ACT_LOAD:
            begin
                in_kind = KIND_NONE;
            end
            ACT_START:
            begin
                in_kind = KIND_START;
            end
            ACT_CHAR:
            begin
                // Newline wins over the table range; carriage return is always dropped.
                if (char_code == CHAR_NEWLINE)
                begin
                    in_kind = KIND_NEWLINE;
                end
                else if ((char_code != CHAR_RETURN) && char_in_range && char_idx_ok)
                begin
                    in_kind = KIND_GLYPH;
                end
            end
            ACT_FINISH:
            begin
                in_kind = KIND_FINISH;
            end
            default:
            begin
                in_kind = KIND_NONE;
            end
        endcase
    end

    // Glyph table: written by load transfers, read for every accepted item.
    always_ff @(posedge clk)
    begin
        if (in_fire && (action_t'(action) == ACT_LOAD) && load_ok)
        begin
            glyph_mem[load_idx[IDX_W-1:0]] <= '{
                width:    glyph_width,
                height:   glyph_height,
                advance:  glyph_advance,
                x_shift:  glyph_x_offset,
                y_shift:  glyph_y_offset
            };
        end
        if (in_fire)
        begin
            glyph_rd_reg <= glyph_mem[char_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_NONE;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
            s1_kind_reg  <= in_kind;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_start_x_reg <= start_x;
            s1_start_y_reg <= start_y;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_char_reg   <= FIRST_CHAR_RESET;
            last_char_reg    <= LAST_CHAR_RESET;
            line_advance_reg <= LINE_ADVANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIRST_CHAR:   first_char_reg   <= cfg_data;
                REG_LAST_CHAR:    last_char_reg    <= cfg_data;
                REG_LINE_ADVANCE: line_advance_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Glyph rectangle. The far edge is cursor plus (offset + size - 1), with the
    // small sum formed next to the near-edge add so only one 32-bit add is in series.
    logic signed [9:0]  far_off_x;
    logic signed [9:0]  far_off_y;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;

    assign far_off_x = 10'(glyph_rd_reg.x_shift) + $signed({2'b00, glyph_rd_reg.width})
                       - 10'sd1;
    assign far_off_y = 10'(glyph_rd_reg.y_shift) + $signed({2'b00, glyph_rd_reg.height})
                       - 10'sd1;
    assign x1 = cursor_x_reg + 32'(glyph_rd_reg.x_shift);
    assign y1 = cursor_y_reg + 32'(glyph_rd_reg.y_shift);
    assign x2 = cursor_x_reg + 32'(far_off_x);
    assign y2 = cursor_y_reg + 32'(far_off_y);

    // Box report from the current state; an axis with no extent reports its origin.
    logic x_has_extent;
    logic y_has_extent;

    assign x_has_extent = !(max_x_reg < min_x_reg);
    assign y_has_extent = !(max_y_reg < min_y_reg);

    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        min_x_next      = min_x_reg;
        min_y_next      = min_y_reg;
        max_x_next      = max_x_reg;
        max_y_next      = max_y_reg;
        out_valid_next  = out_valid_reg && out_stall;
        box_x_next      = box_x_reg;
        box_y_next      = box_y_reg;
        box_width_next  = box_width_reg;
        box_height_next = box_height_reg;

        if (s1_fire)
        begin
            unique case (s1_kind_reg)
                KIND_START:
                begin
                    cursor_x_next = s1_start_x_reg;
                    cursor_y_next = s1_start_y_reg;
                    origin_x_next = s1_start_x_reg;
                    origin_y_next = s1_start_y_reg;
                    min_x_next    = BOX_EMPTY_MIN;
                    min_y_next    = BOX_EMPTY_MIN;
                    max_x_next    = BOX_EMPTY_MAX;
                    max_y_next    = BOX_EMPTY_MAX;
                end
                KIND_NEWLINE:
                begin
                    // The new line starts at column zero, not at the origin.
                    cursor_x_next = '0;
                    cursor_y_next = cursor_y_reg + $signed({24'd0, line_advance_reg});
                end
                KIND_GLYPH:
                begin
                    if (x1 < min_x_reg)
                    begin
                        min_x_next = x1;
                    end
                    if (y1 < min_y_reg)
                    begin
                        min_y_next = y1;
                    end
                    if (max_x_reg < x2)
                    begin
                        max_x_next = x2;
                    end
                    if (max_y_reg < y2)
                    begin
                        max_y_next = y2;
                    end
                    cursor_x_next = cursor_x_reg + $signed({24'd0, glyph_rd_reg.advance});
                end
                KIND_FINISH:
                begin
                    out_valid_next  = 1'b1;
                    box_x_next      = x_has_extent ? min_x_reg : origin_x_reg;
                    box_y_next      = y_has_extent ? min_y_reg : origin_y_reg;
                    box_width_next  = x_has_extent ? 32'(max_x_reg - min_x_reg + 32'sd1) : '0;
                    box_height_next = y_has_extent ? 32'(max_y_reg - min_y_reg + 32'sd1) : '0;
                end
                KIND_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            min_x_reg     <= BOX_EMPTY_MIN;
            min_y_reg     <= BOX_EMPTY_MIN;
            max_x_reg     <= BOX_EMPTY_MAX;
            max_y_reg     <= BOX_EMPTY_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_x_reg      <= box_x_next;
        box_y_reg      <= box_y_next;
        box_width_reg  <= box_width_next;
        box_height_reg <= box_height_next;
    end

    assign out_valid  = out_valid_reg;
    assign box_x      = box_x_reg;
    assign box_y      = box_y_reg;
    assign box_width  = box_width_reg;
    assign box_height = box_height_reg;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for text_bounds_measure: random glyph loads and strings, checked boxes.
module tb_top
    import tbm_pkg::*;
();

    // Size of the glyph table in the block, kept at its default.
    localparam int GLYPH_SLOTS = 128;

    // Six configuration phases, each with its own share of random strings.
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 280;

    // Generous bound on the whole run; a correct run needs only a few percent of it.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Characters used by the directed part, all inside the table range after reset.
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_A     = "A";
    localparam logic [7:0] CH_TILDE = "~";

    // One input transfer with every field, whatever the action uses.
    typedef struct {
        action_t           act;
        logic [6:0]        idx;
        glyph_t            g;
        logic [7:0]        code;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } text_action_t;

    // One reported bounding box.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        w;
        logic [31:0]        h;
    } box_t;

    // The scoreboard carries its own copy of the glyph table, cursor, box and
    // configuration. Every accepted input transfer is applied here, and each
    // finish leaves one expected box behind, to be matched in order against the
    // boxes that come out of the block.
    class box_scoreboard;
        glyph_t             glyphs[GLYPH_SLOTS];
        logic [7:0]         first_c;
        logic [7:0]         last_c;
        logic [7:0]         line_adv;
        logic signed [31:0] cur_x, cur_y, org_x, org_y;
        logic signed [31:0] lo_x, lo_y, hi_x, hi_y;
        box_t               boxes_due[$];
        int                 fails;

        function new();
            foreach (glyphs[i])
                glyphs[i] = '0;
            first_c  = FIRST_CHAR_RESET;
            last_c   = LAST_CHAR_RESET;
            line_adv = LINE_ADVANCE_RESET;
            cur_x    = '0;
            cur_y    = '0;
            org_x    = '0;
            org_y    = '0;
            lo_x     = BOX_EMPTY_MIN;
            lo_y     = BOX_EMPTY_MIN;
            hi_x     = BOX_EMPTY_MAX;
            hi_y     = BOX_EMPTY_MAX;
            fails    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                REG_FIRST_CHAR:   first_c  = v;
                REG_LAST_CHAR:    last_c   = v;
                REG_LINE_ADVANCE: line_adv = v;
                default: ;
            endcase
        endfunction

        // Apply one accepted input transfer to the predicted state.
        function void apply_action(text_action_t it);
            glyph_t             g;
            logic signed [31:0] x1, y1, x2, y2;
            box_t               b;
            int                 gi;
            case (it.act)
                ACT_LOAD:
                    glyphs[it.idx] = it.g;
                ACT_START:
                begin
                    cur_x = it.sx;
                    cur_y = it.sy;
                    org_x = it.sx;
                    org_y = it.sy;
                    lo_x  = BOX_EMPTY_MIN;
                    lo_y  = BOX_EMPTY_MIN;
                    hi_x  = BOX_EMPTY_MAX;
                    hi_y  = BOX_EMPTY_MAX;
                end
                ACT_CHAR:
                begin
                    gi = int'(it.code) - int'(first_c);
                    if (it.code == CHAR_NEWLINE)
                    begin
                        // Newline returns to column zero, not to the origin.
                        cur_x = '0;
                        cur_y = cur_y + {24'd0, line_adv};
                    end
                    else if (it.code != CHAR_RETURN && it.code >= first_c &&
                             it.code <= last_c && gi < GLYPH_SLOTS)
                    begin
                        g  = glyphs[gi];
                        x1 = cur_x + {{24{g.x_shift[7]}}, g.x_shift};
                        y1 = cur_y + {{24{g.y_shift[7]}}, g.y_shift};
                        x2 = x1 + {24'd0, g.width} - 32'd1;
                        y2 = y1 + {24'd0, g.height} - 32'd1;
                        if (x1 < lo_x)
                            lo_x = x1;
                        if (y1 < lo_y)
                            lo_y = y1;
                        if (hi_x < x2)
                            hi_x = x2;
                        if (hi_y < y2)
                            hi_y = y2;
                        cur_x = cur_x + {24'd0, g.advance};
                    end
                end
                ACT_FINISH:
                begin
                    b.x = org_x;
                    b.y = org_y;
                    b.w = '0;
                    b.h = '0;
                    if (!(hi_x < lo_x))
                    begin
                        b.x = lo_x;
                        b.w = hi_x - lo_x + 32'd1;
                    end
                    if (!(hi_y < lo_y))
                    begin
                        b.y = lo_y;
                        b.h = hi_y - lo_y + 32'd1;
                    end
                    boxes_due = {boxes_due, b};
                end
                default: ;
            endcase
        endfunction

        function void check_box(logic signed [31:0] gx, logic signed [31:0] gy,
                                logic [31:0] gw, logic [31:0] gh);
            box_t b;
            if (boxes_due.size() == 0)
            begin
                $error("box result with no expected box pending");
                fails++;
            end
            else
            begin
                b = boxes_due.pop_front();
                if (gx !== b.x)
                begin
                    $error("box_x: expected %0d, got %0d", b.x, gx);
                    fails++;
                end
                if (gy !== b.y)
                begin
                    $error("box_y: expected %0d, got %0d", b.y, gy);
                    fails++;
                end
                if (gw !== b.w)
                begin
                    $error("box_width: expected %0d, got %0d", b.w, gw);
                    fails++;
                end
                if (gh !== b.h)
                begin
                    $error("box_height: expected %0d, got %0d", b.h, gh);
                    fails++;
                end
            end
        endfunction

        function int pending();
            return boxes_due.size();
        endfunction
    endclass

    // Clock, reset and every input of the block start at known values.
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic [1:0]         action         = '0;
    logic [6:0]         glyph_index    = '0;
    logic [7:0]         glyph_width    = '0;
    logic [7:0]         glyph_height   = '0;
    logic [7:0]         glyph_advance  = '0;
    logic signed [7:0]  glyph_x_offset = '0;
    logic signed [7:0]  glyph_y_offset = '0;
    logic [7:0]         char_code      = '0;
    logic signed [31:0] start_x        = '0;
    logic signed [31:0] start_y        = '0;
    logic               out_stall      = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic [1:0]         cfg_index      = '0;
    logic [7:0]         cfg_data       = '0;

    logic               in_stall;
    logic               out_valid;
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic [31:0]        box_width;
    logic [31:0]        box_height;
    logic               cfg_ready;

    box_scoreboard          sb;
    bit [GLYPH_SLOTS-1:0]   glyph_loaded = '0;
    int                     sent_count = 0;
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    int unsigned            cycle_count = 0;

    text_bounds_measure u_dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // The receiver stalls at random with the rate chosen for the current phase.
    always @(posedge clk)
        out_stall <= rst_n ? ($urandom_range(99) < stall_pct) : 1'b0;

    // A result transfer happens at an edge where out_valid is high and out_stall
    // low. Both are read before this edge's updates, so the order of processes
    // within the time step does not matter.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_box(box_x, box_y, box_width, box_height);

    // A byte that favors the corners: zero, all ones and the signed limits.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // A start coordinate, often close to where signed 32-bit arithmetic wraps.
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF - $urandom_range(300);
            1: return 32'h8000_0000 + $urandom_range(300);
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Fields that an action does not use carry random values as well.
    function automatic text_action_t rand_item();
        text_action_t it;
        it.act  = action_t'($urandom_range(3));
        it.idx  = 7'($urandom);
        it.g    = {rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        it.code = 8'($urandom);
        it.sx   = rand_word();
        it.sy   = rand_word();
        return it;
    endfunction

    function automatic text_action_t mk_load(logic [6:0] idx, logic [7:0] w, logic [7:0] h,
                                             logic [7:0] adv, logic [7:0] xo, logic [7:0] yo);
        text_action_t it;
        it     = rand_item();
        it.act = ACT_LOAD;
        it.idx = idx;
        it.g   = {w, h, adv, xo, yo};
        return it;
    endfunction

    function automatic text_action_t mk_start(logic signed [31:0] sx, logic signed [31:0] sy);
        text_action_t it;
        it     = rand_item();
        it.act = ACT_START;
        it.sx  = sx;
        it.sy  = sy;
        return it;
    endfunction

    function automatic text_action_t mk_finish();
        text_action_t it;
        it     = rand_item();
        it.act = ACT_FINISH;
        return it;
    endfunction

    // Character choice for strings: mostly codes inside the table range, with
    // newlines, carriage returns and arbitrary codes mixed in.
    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return CHAR_NEWLINE;
        if (r < 17)
            return CHAR_RETURN;
        if (r < 32 || sb.first_c > sb.last_c)
            return 8'($urandom);
        return 8'($urandom_range(sb.last_c, sb.first_c));
    endfunction

    // Offer one transfer on the input channel. The sender may idle first; once
    // valid is up the payload holds until the block takes it. Valid stays high
    // on return, so a following call continues without a gap.
    task automatic send(text_action_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        action         <= it.act;
        glyph_index    <= it.idx;
        glyph_width    <= it.g.width;
        glyph_height   <= it.g.height;
        glyph_advance  <= it.g.advance;
        glyph_x_offset <= it.g.x_shift;
        glyph_y_offset <= it.g.y_shift;
        char_code      <= it.code;
        start_x        <= it.sx;
        start_y        <= it.sy;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.apply_action(it);
        if (it.act == ACT_LOAD)
            glyph_loaded[it.idx] = 1'b1;
        sent_count++;
    endtask

    // A character that would select a table entry never loaded gets a load of
    // that entry in front of it, so no glyph from an unwritten entry reaches the box.
    task automatic send_char(logic [7:0] code);
        text_action_t it;
        int           gi;
        gi = int'(code) - int'(sb.first_c);
        if (code != CHAR_NEWLINE && code != CHAR_RETURN && code >= sb.first_c &&
            code <= sb.last_c && gi < GLYPH_SLOTS && !glyph_loaded[gi])
            send(mk_load(7'(gi), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                         rand_byte()));
        it      = rand_item();
        it.act  = ACT_CHAR;
        it.code = code;
        send(it);
    endtask

    // A well-formed string: start, a few characters with the odd reload of a
    // glyph, finish, and now and then a repeated finish or characters that keep
    // adding to the box after it has been reported.
    task automatic run_string();
        send(mk_start(rand_word(), rand_word()));
        repeat ($urandom_range(12))
        begin
            if ($urandom_range(19) == 0)
                send(mk_load(7'($urandom), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                             rand_byte()));
            send_char(pick_code());
        end
        send(mk_finish());
        if ($urandom_range(9) == 0)
            send(mk_finish());
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(3, 1))
                send_char(pick_code());
            send(mk_finish());
        end
    endtask

    // Drop valid, wait until every expected box has come out, then let the
    // pipeline run on so that a trailing load, start or character
    // has been applied before anything is reconfigured.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Write all three registers back to back; cfg_valid only drops after the last one.
    task automatic write_config(logic [7:0] new_first, logic [7:0] new_last, logic [7:0] new_adv);
        logic [1:0] regs[3];
        logic [7:0] vals[3];
        regs = '{REG_FIRST_CHAR, REG_LAST_CHAR, REG_LINE_ADVANCE};
        vals = '{new_first, new_last, new_adv};
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        // Table ranges cover the extremes of both bounds, an inverted range, a
        // single-code range, a range wider than the table and one that holds
        // newline and carriage return; the line advance reaches 0 and 255.
        logic [7:0] ph_first[PHASES];
        logic [7:0] ph_last[PHASES];
        logic [7:0] ph_adv[PHASES];
        int         stop_at;
        text_action_t it;

        ph_first = '{8'd32,  8'd0,   8'd255, 8'd0,  8'd200, 8'd10};
        ph_last  = '{8'd126, 8'd255, 8'd255, 8'd0,  8'd50,  8'd137};
        ph_adv   = '{8'd12,  8'd255, 8'd0,   8'd77, 8'd128, 8'd1};

        sb = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, still with the reset configuration. A finish right
        // after reset reports an empty box at the origin.
        send(mk_finish());
        // The space glyph is empty; 'A' has every metric at its largest and both
        // offsets at their most negative; '~' has both offsets at their most positive.
        send(mk_load(7'(CH_SPACE - FIRST_CHAR_RESET), 8'd0, 8'd0, 8'd4, 8'h00, 8'h00));
        send(mk_load(7'(CH_A - FIRST_CHAR_RESET), 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80));
        send(mk_load(7'(CH_TILDE - FIRST_CHAR_RESET), 8'd1, 8'd1, 8'd0, 8'h7F, 8'h7F));
        // The cursor starts at the signed limits, so the first glyph wraps.
        send(mk_start(32'sh7FFF_FFFF, 32'sh8000_0000));
        send_char(CH_A);
        send_char(CH_TILDE);
        send_char(CHAR_RETURN);
        send_char(CHAR_NEWLINE);
        // Codes below and above the table range are ignored.
        send_char(CH_SPACE - 8'd1);
        send_char(CH_TILDE + 8'd1);
        send_char(8'hFF);
        send(mk_finish());
        send(mk_finish());
        // A character after a finish keeps adding to the same box.
        send_char(CH_SPACE);
        send(mk_finish());
        // A string made only of an empty glyph.
        send(mk_start(-32'sd1, 32'sd0));
        send_char(CH_SPACE);
        send(mk_finish());
        send(mk_start(32'sh8000_0000, 32'sh7FFF_FFFF));
        send_char(CH_A);
        send(mk_finish());

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_config(ph_first[p], ph_last[p], ph_adv[p]);
            // Idling pattern per phase: none, sender idle, receiver stalling, both.
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                end
                default:
                begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                end
            endcase
            // Three in four are well-formed strings; the rest is random noise.
            stop_at = sent_count + ITEMS_PER_PHASE;
            while (sent_count < stop_at)
            begin
                if ($urandom_range(3) != 0)
                    run_string();
                else
                begin
                    it = rand_item();
                    if (it.act == ACT_CHAR)
                        send_char(pick_code());
                    else
                        send(it);
                end
            end
        end

        wait_drained();
        if (sb.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/tbm_pkg.sv
hdl/text_bounds_measure.sv
test/tb_top.sv
